// File: sv/hpbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpbs_pkg
// Shared types and constants of the histogram peak-bin statistics core.
// ----------------------------------------------------------------------------
package hpbs_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int MAX_BINS   = 4096;
   localparam int MAX_WIDTH  = 256;
   localparam int COORD_BITS = 12;

   localparam int PT_AW   = $clog2(MAX_POINTS);
   localparam int BIN_AW  = $clog2(MAX_BINS);
   localparam int FINE_AW = $clog2(MAX_WIDTH);
   localparam int CNT_W   = 11;
   localparam int SUM_W   = 22;
   localparam int DIVR_W  = 12;
   localparam int STEP_W  = $clog2(SUM_W);

   localparam logic [8:0] WIDTH_RESET = 9'd16;
   localparam logic [11:0] BOUND_RESET = 12'd4095;
   localparam logic [8:0] WIDTH_MAX_V = 9'd256;

   // register indexes
   localparam logic REG_BIN_WIDTH   = 1'b0;
   localparam logic REG_COORD_BOUND = 1'b1;

   typedef struct packed {
      logic              start;
      logic [SUM_W-1:0]  dividend;
      logic [DIVR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

endpackage : hpbs_pkg
`default_nettype wire

// File: sv/histogram_peak_bin_statistics_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_peak_bin_statistics_core
// Top two histogram bins of a coordinate set with mean and mode, plus the median of the best bin.
// ----------------------------------------------------------------------------
// Usage:
//  - Input: a transfer happens on a clock edge with start high and busy low.
//    Each coordinate is written to the point memory; busy stays low while loading.
//    A transfer with req_last high closes the set and starts evaluation.
//  - Evaluation is run by one sequencer around a single shared divider and
//    point, coarse-bin and fine-bin memories with one write and one read
//    port each. Steps: divide for the bin count, clear the coarse bins, divide
//    each stored point into its coarse bin (zero points and points above the
//    last bin are not counted), scan the coarse bins, then per bin clear,
//    fill and scan the fine bins, divide for the mean and save (points and
//    mean skipped for an empty bin). Busy is high for all of it.
//  - Output: rsp_valid strobes for one cycle with all result fields; the
//    receiver cannot stall and must take it. The set is then cleared.
//  - Points beyond 1024 are dropped and reported in rsp_overflow.
//  - CSR port: csr_ready is always high; write only while the block is idle.
//  - Reset (synchronous) empties the set and loads bin_width 16 and
//    coord_bound 4095. No clearing pass: memories are cleared per set.
// ----------------------------------------------------------------------------
module histogram_peak_bin_statistics_core
   import hpbs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [11:0] req_coord,
   input  wire logic        req_last,
   output logic             rsp_valid,
   output logic [11:0]      rsp_best_bin_low,
   output logic [10:0]      rsp_best_count,
   output logic [11:0]      rsp_best_mean,
   output logic [11:0]      rsp_best_mode,
   output logic [11:0]      rsp_best_median,
   output logic [11:0]      rsp_second_bin_low,
   output logic [10:0]      rsp_second_count,
   output logic [11:0]      rsp_second_mean,
   output logic [11:0]      rsp_second_mode,
   output logic             rsp_overflow,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [11:0] csr_wdata
);

   typedef enum logic [19:0] {
      ST_IDLE  = 20'h00001,
      ST_NB    = 20'h00002,
      ST_CCLR  = 20'h00004,
      ST_PRD   = 20'h00008,
      ST_PCHK  = 20'h00010,
      ST_PDIV  = 20'h00020,
      ST_CRD   = 20'h00040,
      ST_CWR   = 20'h00080,
      ST_SRD   = 20'h00100,
      ST_SCHK  = 20'h00200,
      ST_BSET  = 20'h00400,
      ST_FCLR  = 20'h00800,
      ST_FRD   = 20'h01000,
      ST_FCHK  = 20'h02000,
      ST_FINC  = 20'h04000,
      ST_FSRD  = 20'h08000,
      ST_FSCHK = 20'h10000,
      ST_MEAN  = 20'h20000,
      ST_SAVE  = 20'h40000,
      ST_OUT   = 20'h80000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [8:0]  bin_width_ff, bin_width_in;
   logic [11:0] coord_bound_ff, coord_bound_in;
   logic [8:0]  w_eff;

   // set bookkeeping
   logic [CNT_W-1:0] pcount_ff, pcount_in;
   logic             dropped_ff, dropped_in;

   // sequencer working registers
   logic [11:0]        cnt_ff, cnt_in;
   logic [11:0]        nb_ff, nb_in;
   logic [11:0]        bin_ff, bin_in;
   logic [CNT_W-1:0]   c1_ff, c1_in, c2_ff, c2_in;
   logic [11:0]        b1_ff, b1_in, b2_ff, b2_in;
   logic               sel_ff, sel_in;
   logic [19:0]        low_ff, low_in;
   logic [FINE_AW-1:0] foff_ff, foff_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0]   mbest_ff, mbest_in;
   logic [FINE_AW-1:0] mi_ff, mi_in;
   logic [FINE_AW-1:0] ra_ff, ra_in, rb_ff, rb_in;
   logic               ga_ff, ga_in, gb_ff, gb_in;
   logic [11:0]        mean_ff, mean_in;

   // result registers
   logic        valid_ff, valid_in;
   logic [11:0] best_low_ff, best_low_in, best_mean_ff, best_mean_in;
   logic [11:0] best_mode_ff, best_mode_in, best_med_ff, best_med_in;
   logic [10:0] best_cnt_ff, best_cnt_in;
   logic [11:0] sec_low_ff, sec_low_in, sec_mean_ff, sec_mean_in;
   logic [11:0] sec_mode_ff, sec_mode_in;
   logic [10:0] sec_cnt_ff, sec_cnt_in;
   logic        ovf_ff, ovf_in;

   // memories
   logic [11:0]      pt_mem [MAX_POINTS];
   logic [CNT_W-1:0] coarse_mem [MAX_BINS];
   logic [CNT_W-1:0] fine_mem [MAX_WIDTH];
   logic [11:0]      pt_q;
   logic [CNT_W-1:0] coarse_q, fine_q;
   logic             pt_we, coarse_we, fine_we;
   logic [BIN_AW-1:0]  coarse_waddr, coarse_raddr;
   logic [CNT_W-1:0]   coarse_wdata, fine_wdata;
   logic [FINE_AW-1:0] fine_waddr, fine_raddr;

   div_req_type div_req;
   div_rsp_type div_rsp;

   // combinational helpers
   logic             accept;
   logic [11:0]      bidx;
   logic [CNT_W-1:0] bcnt;
   logic [20:0]      low_x, hi_x, pt_x;
   logic             in_bin;
   logic [20:0]      foff_x;
   logic [CNT_W-1:0] acc_nx, ka, kb;
   logic [11:0]      cnt_nx;
   logic             pt_end;
   logic [20:0]      mode_x, med_sum;
   logic [11:0]      median;
   logic [19:0]      mult;

   hpbs_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      if (bin_width_ff == 9'd0) begin
         w_eff = 9'd1;
      end else if (bin_width_ff > WIDTH_MAX_V) begin
         w_eff = WIDTH_MAX_V;
      end else begin
         w_eff = bin_width_ff;
      end
   end

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign bidx    = sel_ff ? b2_ff : b1_ff;
   assign bcnt    = sel_ff ? c2_ff : c1_ff;
   assign mult    = 20'(bidx * w_eff);
   assign low_x   = {1'b0, low_ff};
   assign hi_x    = low_x + {12'd0, w_eff};
   assign pt_x    = {9'd0, pt_q};
   assign in_bin  = (pt_x > low_x) && (pt_x <= hi_x);
   assign foff_x  = pt_x - low_x - 21'd1;
   assign acc_nx  = acc_ff + fine_q;
   assign ka      = (n_ff - 1'b1) >> 1;
   assign kb      = n_ff >> 1;
   assign cnt_nx  = cnt_ff + 1'b1;
   assign pt_end  = (cnt_nx == {1'b0, pcount_ff});
   assign mode_x  = low_x + 21'd1 + {13'd0, mi_ff};
   // rank values share the low+1 base; average of the pair (same when odd)
   assign med_sum = low_x + low_x + 21'd2 + {13'd0, ra_ff} + {13'd0, rb_ff};
   assign median  = (n_ff == '0) ? 12'd0 : med_sum[12:1];

   always_comb begin
      state_in       = state_ff;
      bin_width_in   = bin_width_ff;
      coord_bound_in = coord_bound_ff;
      pcount_in      = pcount_ff;
      dropped_in     = dropped_ff;
      cnt_in   = cnt_ff;   nb_in    = nb_ff;    bin_in   = bin_ff;
      c1_in    = c1_ff;    c2_in    = c2_ff;    b1_in    = b1_ff;    b2_in = b2_ff;
      sel_in   = sel_ff;   low_in   = low_ff;   foff_in  = foff_ff;
      sum_in   = sum_ff;   n_in     = n_ff;     acc_in   = acc_ff;
      mbest_in = mbest_ff; mi_in    = mi_ff;    ra_in    = ra_ff;    rb_in = rb_ff;
      ga_in    = ga_ff;    gb_in    = gb_ff;    mean_in  = mean_ff;
      valid_in     = 1'b0;
      best_low_in  = best_low_ff;  best_cnt_in  = best_cnt_ff;
      best_mean_in = best_mean_ff; best_mode_in = best_mode_ff;
      best_med_in  = best_med_ff;
      sec_low_in   = sec_low_ff;   sec_cnt_in   = sec_cnt_ff;
      sec_mean_in  = sec_mean_ff;  sec_mode_in  = sec_mode_ff;
      ovf_in       = ovf_ff;
      pt_we        = 1'b0;
      coarse_we    = 1'b0;
      coarse_waddr = cnt_ff;
      coarse_wdata = '0;
      coarse_raddr = cnt_ff;
      fine_we      = 1'b0;
      fine_waddr   = cnt_ff[FINE_AW-1:0];
      fine_wdata   = '0;
      fine_raddr   = cnt_ff[FINE_AW-1:0];
      div_req.start    = 1'b0;
      div_req.dividend = {10'd0, pt_q - 12'd1};
      div_req.divisor  = {3'd0, w_eff};

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_BIN_WIDTH:   bin_width_in   = csr_wdata[8:0];
            REG_COORD_BOUND: coord_bound_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (pcount_ff < CNT_W'(MAX_POINTS)) begin
                  pt_we     = 1'b1;
                  pcount_in = pcount_ff + 1'b1;
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = {10'd0, coord_bound_ff};
                  c1_in = '0; c2_in = '0; b1_in = '0; b2_in = '0;
                  cnt_in   = '0;
                  state_in = ST_NB;
               end
            end
         end
         ST_NB: begin
            if (div_rsp.done) begin
               nb_in    = div_rsp.quotient[11:0];
               state_in = ST_CCLR;
            end
         end
         ST_CCLR: begin
            if (cnt_ff == nb_ff) begin
               cnt_in   = '0;
               state_in = ST_PRD;
            end else begin
               coarse_we = 1'b1;
               cnt_in    = cnt_nx;
            end
         end
         ST_PRD: state_in = ST_PCHK;
         ST_PCHK: begin
            if (pt_q == 12'd0) begin
               cnt_in   = pt_end ? 12'd0 : cnt_nx;
               state_in = pt_end ? ST_SRD : ST_PRD;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_PDIV;
            end
         end
         ST_PDIV: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient < {10'd0, nb_ff}) begin
                  bin_in   = div_rsp.quotient[11:0];
                  state_in = ST_CRD;
               end else begin
                  cnt_in   = pt_end ? 12'd0 : cnt_nx;
                  state_in = pt_end ? ST_SRD : ST_PRD;
               end
            end
         end
         ST_CRD: begin
            coarse_raddr = bin_ff;
            state_in     = ST_CWR;
         end
         ST_CWR: begin
            coarse_we    = 1'b1;
            coarse_waddr = bin_ff;
            coarse_wdata = coarse_q + 1'b1;
            cnt_in       = pt_end ? 12'd0 : cnt_nx;
            state_in     = pt_end ? ST_SRD : ST_PRD;
         end
         ST_SRD: begin
            if (cnt_ff == nb_ff) begin
               sel_in   = 1'b0;
               state_in = ST_BSET;
            end else begin
               state_in = ST_SCHK;
            end
         end
         ST_SCHK: begin
            // running top two; strict compares keep the lower index on ties
            if (coarse_q > c1_ff) begin
               c2_in = c1_ff; b2_in = b1_ff;
               c1_in = coarse_q; b1_in = cnt_ff;
            end else if (coarse_q > c2_ff) begin
               c2_in = coarse_q; b2_in = cnt_ff;
            end
            cnt_in   = cnt_nx;
            state_in = ST_SRD;
         end
         ST_BSET: begin
            low_in = mult;
            cnt_in = '0;
            sum_in = '0; n_in = '0; acc_in = '0; mbest_in = '0; mi_in = '0;
            ra_in  = '0; rb_in = '0; ga_in = 1'b0; gb_in = 1'b0;
            state_in = ST_FCLR;
         end
         ST_FCLR: begin
            if (cnt_ff == {3'd0, w_eff}) begin
               cnt_in   = '0;
               state_in = (bcnt == '0) ? ST_FSRD : ST_FRD;
            end else begin
               fine_we = 1'b1;
               cnt_in  = cnt_nx;
            end
         end
         ST_FRD: state_in = ST_FCHK;
         ST_FCHK: begin
            fine_raddr = foff_x[FINE_AW-1:0];
            if (in_bin) begin
               foff_in  = foff_x[FINE_AW-1:0];
               state_in = ST_FINC;
            end else begin
               cnt_in   = pt_end ? 12'd0 : cnt_nx;
               state_in = pt_end ? ST_FSRD : ST_FRD;
            end
         end
         ST_FINC: begin
            fine_we    = 1'b1;
            fine_waddr = foff_ff;
            fine_wdata = fine_q + 1'b1;
            sum_in     = sum_ff + {10'd0, pt_q};
            n_in       = n_ff + 1'b1;
            cnt_in     = pt_end ? 12'd0 : cnt_nx;
            state_in   = pt_end ? ST_FSRD : ST_FRD;
         end
         ST_FSRD: begin
            if (cnt_ff == {3'd0, w_eff}) begin
               if (n_ff == '0) begin
                  mean_in  = '0;
                  state_in = ST_SAVE;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = sum_ff;
                  div_req.divisor  = {1'b0, n_ff};
                  state_in         = ST_MEAN;
               end
            end else begin
               state_in = ST_FSCHK;
            end
         end
         ST_FSCHK: begin
            acc_in = acc_nx;
            if (fine_q > mbest_ff) begin
               mbest_in = fine_q;
               mi_in    = cnt_ff[FINE_AW-1:0];
            end
            if (!ga_ff && (acc_nx > ka)) begin
               ga_in = 1'b1;
               ra_in = cnt_ff[FINE_AW-1:0];
            end
            if (!gb_ff && (acc_nx > kb)) begin
               gb_in = 1'b1;
               rb_in = cnt_ff[FINE_AW-1:0];
            end
            cnt_in   = cnt_nx;
            state_in = ST_FSRD;
         end
         ST_MEAN: begin
            if (div_rsp.done) begin
               mean_in  = div_rsp.quotient[11:0];
               state_in = ST_SAVE;
            end
         end
         ST_SAVE: begin
            if (!sel_ff) begin
               best_low_in  = low_ff[11:0];
               best_cnt_in  = bcnt;
               best_mean_in = mean_ff;
               best_mode_in = mode_x[11:0];
               best_med_in  = median;
               sel_in       = 1'b1;
               state_in     = ST_BSET;
            end else begin
               sec_low_in  = low_ff[11:0];
               sec_cnt_in  = bcnt;
               sec_mean_in = mean_ff;
               sec_mode_in = mode_x[11:0];
               state_in    = ST_OUT;
            end
         end
         ST_OUT: begin
            valid_in   = 1'b1;
            ovf_in     = dropped_ff;
            pcount_in  = '0;
            dropped_in = 1'b0;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memories, registered read
   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_mem[pcount_ff[PT_AW-1:0]] <= req_coord;
      end
      pt_q <= pt_mem[cnt_ff[PT_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (coarse_we) begin
         coarse_mem[coarse_waddr] <= coarse_wdata;
      end
      coarse_q <= coarse_mem[coarse_raddr];
   end

   always_ff @(posedge clock) begin
      if (fine_we) begin
         fine_mem[fine_waddr] <= fine_wdata;
      end
      fine_q <= fine_mem[fine_raddr];
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;   nb_ff   <= nb_in;   bin_ff  <= bin_in;
      c1_ff    <= c1_in;    c2_ff   <= c2_in;   b1_ff   <= b1_in;   b2_ff <= b2_in;
      sel_ff   <= sel_in;   low_ff  <= low_in;  foff_ff <= foff_in;
      sum_ff   <= sum_in;   n_ff    <= n_in;    acc_ff  <= acc_in;
      mbest_ff <= mbest_in; mi_ff   <= mi_in;   ra_ff   <= ra_in;   rb_ff <= rb_in;
      ga_ff    <= ga_in;    gb_ff   <= gb_in;   mean_ff <= mean_in;
      best_low_ff  <= best_low_in;  best_cnt_ff  <= best_cnt_in;
      best_mean_ff <= best_mean_in; best_mode_ff <= best_mode_in;
      best_med_ff  <= best_med_in;
      sec_low_ff   <= sec_low_in;   sec_cnt_ff   <= sec_cnt_in;
      sec_mean_ff  <= sec_mean_in;  sec_mode_ff  <= sec_mode_in;
      ovf_ff       <= ovf_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         bin_width_ff   <= WIDTH_RESET;
         coord_bound_ff <= BOUND_RESET;
         pcount_ff      <= '0;
         dropped_ff     <= 1'b0;
         valid_ff       <= 1'b0;
      end else begin
         state_ff       <= state_in;
         bin_width_ff   <= bin_width_in;
         coord_bound_ff <= coord_bound_in;
         pcount_ff      <= pcount_in;
         dropped_ff     <= dropped_in;
         valid_ff       <= valid_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_best_bin_low   = best_low_ff;
   assign rsp_best_count     = best_cnt_ff;
   assign rsp_best_mean      = best_mean_ff;
   assign rsp_best_mode      = best_mode_ff;
   assign rsp_best_median    = best_med_ff;
   assign rsp_second_bin_low = sec_low_ff;
   assign rsp_second_count   = sec_cnt_ff;
   assign rsp_second_mean    = sec_mean_ff;
   assign rsp_second_mode    = sec_mode_ff;
   assign rsp_overflow       = ovf_ff;

   // a non-final transfer only loads, it never starts an evaluation
   a_load_only: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_last) |=> !busy)
      else $error("non-final transfer started evaluation");

   // the runner-up never outranks the best bin
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_best_count >= rsp_second_count))
      else $error("runner-up count above best count");

   // result strobe lasts one cycle and comes while the block is idle
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && !$past(rsp_valid)))
      else $error("result strobe malformed");

   // the point count never exceeds the store depth
   a_cap: assert property (@(posedge clock) disable iff (reset)
      pcount_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond capacity");

endmodule : histogram_peak_bin_statistics_core
`default_nettype wire

// File: sv/hpbs_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpbs_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hpbs_divider
   import hpbs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic [DIVR_W-1:0] rem_ff, rem_in;
   logic [DIVR_W-1:0] dvs_ff, dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DIVR_W:0]   rem_sh;
   logic [DIVR_W:0]   rem_sub;
   logic              q_bit;

   always_comb begin
      rem_sh  = {rem_ff, acc_ff[SUM_W-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      q_bit   = (rem_sh >= {1'b0, dvs_ff});
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         acc_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         acc_in  = {acc_ff[SUM_W-2:0], q_bit};
         rem_in  = q_bit ? rem_sub[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = acc_ff;

endmodule : hpbs_divider
`default_nettype wire
